FILE: hw/rtl/wmmd_pkg.sv
package wmmd_pkg;

    // Widths of the configuration registers and of the column counter.
    localparam int START_BITS  = 32;
    localparam int STEP_BITS   = 16;
    localparam int COLUMN_BITS = 13;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LINE_MODE    = 2'd0,
        REG_WINDOW_START = 2'd1,
        REG_STEP_SIZE    = 2'd2,
        REG_COLUMN_COUNT = 2'd3
    } cfg_reg_t;

    // Last count of the window precompute after a register write: a load step,
    // one step per quotient bit, then a step to form the end indexes.
    localparam int CALC_LAST = COLUMN_BITS + 1;
    localparam int CALC_CNT_BITS = $clog2(CALC_LAST + 1);

endpackage

FILE: hw/rtl/waveform_min_max_decimator_unit.sv
// Min/max waveform decimator.
// Input channel s_*: one audio sample per beat; s_tuser marks the first sample
// of a recording (index restarts at zero), s_tlast marks its final sample.
// Output channel m_*: one result beat per finished peak bucket, or per sample
// inside the window in line mode; m_tlast marks the last result of a window.
// Configuration: cfg_we writes cfg_data into register cfg_index (line mode,
// window start, step size, column count) in the same clock edge.
// Throughput is one sample per cycle while s_tready is high. A result is
// registered in the output register, or in the skid register if that is full.
// After each register write the block forms the window end
// indexes (a 13-step shift-subtract divider for the line count, one multiply
// for the peak span); s_tready stays low during that time.
// A two-entry output stage (output register plus skid register) keeps input
// accepted while a result waits; with both full, s_tready drops until the
// receiver takes a beat.
// Reset clears the counters, the window state and the output valid flags and
// loads register defaults: peak mode, start 0, step 1, one column.
module waveform_min_max_decimator_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int INDEX_BITS  = 32,
    parameter int MAX_COLUMNS = 4096
) (
    input  logic clk,
    input  logic rst_n,

    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // sample_value
    input  logic                                 s_tuser,   // first_sample
    input  logic                                 s_tlast,   // last_sample

    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // peak_low, peak_high, column_index, zero fill
    output logic [((2*SAMPLE_BITS+wmmd_pkg::COLUMN_BITS+7)/8)*8-1:0] m_tdata,
    output logic                                 m_tlast,   // window_end

    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [wmmd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wmmd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import wmmd_pkg::*;

    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = 2 * SAMPLE_BITS + COLUMN_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    // Window end indexes stay below start + 2^28, so compare two bits above the start.
    localparam int CMP_BITS = (INDEX_BITS > START_BITS + 1) ? INDEX_BITS : START_BITS + 2;
    localparam int PROD_BITS = COLUMN_BITS + STEP_BITS;

    // Configuration registers.
    logic                   line_mode_reg;
    logic [START_BITS-1:0]  window_start_reg;
    logic [STEP_BITS-1:0]   step_size_reg;
    logic [COLUMN_BITS-1:0] column_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg    <= 1'b0;
            window_start_reg <= '0;
            step_size_reg    <= STEP_BITS'(1);
            column_count_reg <= COLUMN_BITS'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LINE_MODE:    line_mode_reg    <= cfg_data[0];
                REG_WINDOW_START: window_start_reg <= cfg_data[START_BITS-1:0];
                REG_STEP_SIZE:    step_size_reg    <= cfg_data[STEP_BITS-1:0];
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[COLUMN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Effective step (zero counts as one) and clamped window width.
    logic [STEP_BITS-1:0]   step_eff;
    logic [COLUMN_BITS-1:0] width_eff;

    assign step_eff  = (step_size_reg == '0) ? STEP_BITS'(1) : step_size_reg;
    assign width_eff = (32'(column_count_reg) > MAX_COLUMNS) ? COLUMN_BITS'(MAX_COLUMNS)
                                                             : column_count_reg;

    // Window end precompute: shift-subtract divider for ceil(width / step)
    // and one multiply for the peak span, restarted by every register write.
    logic                     calc_busy_reg;
    logic [CALC_CNT_BITS-1:0] calc_cnt_reg;
    logic [COLUMN_BITS-1:0]   quo_reg;
    logic [STEP_BITS-1:0]     rem_reg;
    logic [PROD_BITS-1:0]     prod_reg;
    logic [CMP_BITS-1:0]      line_end_reg;
    logic [CMP_BITS-1:0]      peak_end_reg;

    logic [STEP_BITS:0]       rem_shift;
    logic                     rem_ge;
    logic [STEP_BITS:0]       rem_sub;

    assign rem_shift = {rem_reg, quo_reg[COLUMN_BITS-1]};
    assign rem_ge    = rem_shift >= {1'b0, step_eff};
    assign rem_sub   = rem_shift - {1'b0, step_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_busy_reg <= 1'b0;
            calc_cnt_reg  <= '0;
            line_end_reg  <= CMP_BITS'(1);
            peak_end_reg  <= '0;
        end
        else if (cfg_we)
        begin
            calc_busy_reg <= 1'b1;
            calc_cnt_reg  <= '0;
        end
        else if (calc_busy_reg)
        begin
            calc_cnt_reg <= calc_cnt_reg + CALC_CNT_BITS'(1);
            if (calc_cnt_reg == CALC_CNT_BITS'(CALC_LAST))
            begin
                calc_busy_reg <= 1'b0;
                line_end_reg  <= CMP_BITS'(window_start_reg) + CMP_BITS'(quo_reg)
                                 + CMP_BITS'(rem_reg != '0);
                peak_end_reg  <= CMP_BITS'(window_start_reg) + CMP_BITS'(prod_reg)
                                 - CMP_BITS'(1);
            end
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        if (calc_busy_reg)
        begin
            if (calc_cnt_reg == '0)
            begin
                quo_reg  <= width_eff;
                rem_reg  <= '0;
                prod_reg <= PROD_BITS'(width_eff) * PROD_BITS'(step_eff);
            end
            else if (calc_cnt_reg != CALC_CNT_BITS'(CALC_LAST))
            begin
                rem_reg <= rem_ge ? rem_sub[STEP_BITS-1:0] : rem_shift[STEP_BITS-1:0];
                quo_reg <= {quo_reg[COLUMN_BITS-2:0], rem_ge};
            end
        end
    end

    // Window state.
    logic [INDEX_BITS-1:0]  position_reg;
    logic [STEP_BITS-1:0]   fill_reg;
    logic [COLUMN_BITS-1:0] columns_reg;
    logic [SAMPLE_BITS-1:0] run_low_reg;
    logic [SAMPLE_BITS-1:0] run_high_reg;
    logic                   closed_reg;

    logic [INDEX_BITS-1:0]  position_next;
    logic [STEP_BITS-1:0]   fill_next;
    logic [COLUMN_BITS-1:0] columns_next;
    logic [SAMPLE_BITS-1:0] run_low_next;
    logic [SAMPLE_BITS-1:0] run_high_next;
    logic                   closed_next;

    logic                   accept;
    logic                   res_valid;
    logic                   res_end;
    logic [SAMPLE_BITS-1:0] res_low;
    logic [SAMPLE_BITS-1:0] res_high;

    logic signed [SAMPLE_BITS-1:0] sample;
    logic [INDEX_BITS-1:0]  idx;
    logic [CMP_BITS-1:0]    idx_wide;
    logic                   after_start;
    logic [STEP_BITS-1:0]   fill_base;
    logic [STEP_BITS-1:0]   fill_inc;
    logic                   closed_base;
    logic [COLUMN_BITS-1:0] columns_base;
    logic                   is_end;

    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign idx      = s_tuser ? '0 : position_reg;
    assign idx_wide = CMP_BITS'(idx);
    assign after_start = idx_wide >= CMP_BITS'(window_start_reg);
    assign fill_base    = s_tuser ? '0 : fill_reg;
    assign closed_base  = s_tuser ? 1'b0 : closed_reg;
    assign columns_base = s_tuser ? '0 : columns_reg;
    assign fill_inc     = fill_base + STEP_BITS'(1);

    // Per-sample update: bucket extremes, column count and window close.
    always_comb
    begin
        position_next = (&idx) ? idx : idx + INDEX_BITS'(1);
        fill_next     = fill_base;
        columns_next  = columns_base;
        run_low_next  = run_low_reg;
        run_high_next = run_high_reg;
        closed_next   = closed_base;
        res_valid     = 1'b0;
        res_end       = 1'b0;
        res_low       = sample;
        res_high      = sample;
        is_end        = 1'b0;

        if (!closed_base)
        begin
            if (line_mode_reg)
            begin
                if (after_start && idx_wide <= line_end_reg)
                begin
                    is_end       = (idx_wide == line_end_reg) || s_tlast;
                    res_valid    = 1'b1;
                    res_end      = is_end;
                    columns_next = columns_base + COLUMN_BITS'(1);
                    if (is_end)
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
            else if (width_eff != '0 && after_start && idx_wide <= peak_end_reg)
            begin
                if (fill_base == '0)
                begin
                    run_low_next  = sample;
                    run_high_next = sample;
                end
                else if (sample < $signed(run_low_reg))
                begin
                    run_low_next = sample;
                end
                else if (sample > $signed(run_high_reg))
                begin
                    run_high_next = sample;
                end
                fill_next = fill_inc;
                is_end    = (idx_wide == peak_end_reg) || s_tlast;
                res_low   = run_low_next;
                res_high  = run_high_next;
                if (fill_inc >= step_eff || is_end)
                begin
                    res_valid    = 1'b1;
                    res_end      = is_end;
                    columns_next = columns_base + COLUMN_BITS'(1);
                    fill_next    = '0;
                    if (is_end)
                    begin
                        closed_next = 1'b1;
                    end
                end
            end
        end

        // The end of a recording closes the window and drops an open bucket.
        if (s_tlast)
        begin
            closed_next = 1'b1;
            fill_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            fill_reg     <= '0;
            columns_reg  <= '0;
            run_low_reg  <= '0;
            run_high_reg <= '0;
            closed_reg   <= 1'b0;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            fill_reg     <= fill_next;
            columns_reg  <= columns_next;
            run_low_reg  <= run_low_next;
            run_high_reg <= run_high_next;
            closed_reg   <= closed_next;
        end
    end

    // Output register and skid register.
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_low_reg;
    logic [SAMPLE_BITS-1:0] out_high_reg;
    logic [COLUMN_BITS-1:0] out_col_reg;
    logic                   out_end_reg;
    logic                   skid_valid_reg;
    logic [SAMPLE_BITS-1:0] skid_low_reg;
    logic [SAMPLE_BITS-1:0] skid_high_reg;
    logic [COLUMN_BITS-1:0] skid_col_reg;
    logic                   skid_end_reg;

    logic push;
    logic out_free;

    assign push     = accept && res_valid;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg && !calc_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_low_reg  <= skid_low_reg;
                out_high_reg <= skid_high_reg;
                out_col_reg  <= skid_col_reg;
                out_end_reg  <= skid_end_reg;
            end
            else if (push)
            begin
                out_low_reg  <= res_low;
                out_high_reg <= res_high;
                out_col_reg  <= columns_base;
                out_end_reg  <= res_end;
            end
        end
        else if (push)
        begin
            skid_low_reg  <= res_low;
            skid_high_reg <= res_high;
            skid_col_reg  <= columns_base;
            skid_end_reg  <= res_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_end_reg;
    assign m_tdata  = OUT_TDATA_BITS'({out_col_reg, out_high_reg, out_low_reg});

    // The sample port may be wider than a sample; the fill bits are not used.
    logic unused_fill;
    assign unused_fill = ^s_tdata[IN_TDATA_BITS-1:SAMPLE_BITS-1];

    // The skid register only fills behind a waiting output beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    // No sample is taken while the window ends are being recomputed.
    assert property (@(posedge clk) disable iff (!rst_n)
        calc_busy_reg |-> !s_tready)
        else $error("sample accepted during window precompute");

    // A result that ends the window leaves the window closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_end) |=> closed_reg)
        else $error("window still open after its last result");

    // A beat pushed into a full output stage is kept in the skid register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_free) |=> skid_valid_reg)
        else $error("stalled result was not kept in the skid register");

endmodule
